@@ hdl/assert_macros.svh @@
// Assertion macros used by the checker file of the score list.
// No dependencies; included by name from any file that asserts.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define TKSL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("score list check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define TKSL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("score list check failed");

`endif

@@ hdl/tksl_pkg.sv @@
// Package of the top-K score list: sizes, codes and the controller command bundle.
// No dependencies; imported by every module of the block.
package tksl_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int SCORE_W     = 32;
    localparam int TAG_W       = 32;
    localparam int LSIZE_W     = 5;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int CLAMP_W     = (LSIZE_W > CNT_W) ? LSIZE_W : CNT_W;

    localparam int LIST_SIZE_RESET = 5;
    localparam logic [CNT_W-1:0] COUNT_RESET =
        CNT_W'((LIST_SIZE_RESET > MAX_ENTRIES) ? MAX_ENTRIES : LIST_SIZE_RESET);

    localparam logic OP_OFFER = 1'b0;
    localparam logic OP_READ  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_LIST_SIZE   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_COLLECT_ALL = CFG_IDX_W'(1);

    typedef struct packed {
        logic capture;
        logic compare;
        logic update;
        logic cfg_we;
    } t_cmd;

    // Limits a written list size to the range one to the list depth.
    function automatic logic [CNT_W-1:0] clamp_size(input logic [LSIZE_W-1:0] v);
        logic [CLAMP_W-1:0] w;
        w = CLAMP_W'(v);
        if (w == '0) begin
            w = CLAMP_W'(1);
        end
        if (w > CLAMP_W'(MAX_ENTRIES)) begin
            w = CLAMP_W'(MAX_ENTRIES);
        end
        return w[CNT_W-1:0];
    endfunction

endpackage

@@ hdl/top_k_score_list.sv @@
// Top level of the top-K score list: joins the controller and the datapath.
// Depends on tksl_pkg, tksl_ctrl and tksl_dp.
//
// The block keeps a descending list of up to sixteen best scores, each with a
// configuration tag and a coefficient tag. A command beat is taken at a rising
// edge where start is high and busy is low. Every command takes three steps:
// one to capture the beat, one in which all sixteen cells compare their score
// with the offered one in parallel, and one in which the cells load, shift or
// clear and the result registers fill. The result beat is shown on the o_ ports
// for exactly one cycle, marked by o_done, which is registered at the end of the
// update step like the result registers; the receiver cannot stall it, so it must
// be ready to take every result. Busy falls in the same cycle that o_done rises,
// so a new command can be taken while the previous result is on the ports; the
// three-step sequencer takes no new command until it is idle. Register writes go
// through the config channel (index 0 list size, index 1 collect-all mode) and
// are taken only while the block is not busy; writes to other indexes are
// ignored. After reset the list holds five zero entries and is ready at once.
module top_k_score_list (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    output logic                                  o_done,
    input  logic                                  i_opcode,
    input  logic signed [tksl_pkg::SCORE_W-1:0]   i_score,
    input  logic [tksl_pkg::TAG_W-1:0]            i_config_id,
    input  logic [tksl_pkg::TAG_W-1:0]            i_coeff_tag,
    input  logic [tksl_pkg::IDX_W-1:0]            i_read_index,
    output logic                                  o_accepted,
    output logic [tksl_pkg::IDX_W-1:0]            o_position,
    output logic [tksl_pkg::CNT_W-1:0]            o_entry_count,
    output logic                                  o_overflow,
    output logic signed [tksl_pkg::SCORE_W-1:0]   o_read_score,
    output logic [tksl_pkg::TAG_W-1:0]            o_read_config_id,
    output logic [tksl_pkg::TAG_W-1:0]            o_read_coeff_tag,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [tksl_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [tksl_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import tksl_pkg::*;

    // Command bundle from the sequencer to the cells.
    t_cmd cmd;

    tksl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_cfg_valid (i_cfg_valid),
        .o_busy      (busy),
        .o_cfg_ready (o_cfg_ready),
        .o_done      (o_done),
        .o_cmd       (cmd)
    );

    tksl_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_opcode         (i_opcode),
        .i_score          (i_score),
        .i_config_id      (i_config_id),
        .i_coeff_tag      (i_coeff_tag),
        .i_read_index     (i_read_index),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_accepted       (o_accepted),
        .o_position       (o_position),
        .o_entry_count    (o_entry_count),
        .o_overflow       (o_overflow),
        .o_read_score     (o_read_score),
        .o_read_config_id (o_read_config_id),
        .o_read_coeff_tag (o_read_coeff_tag)
    );

endmodule

@@ hdl/tksl_ctrl.sv @@
// Controller of the score list: a three-state sequencer that issues datapath commands.
// Depends on tksl_pkg.
module tksl_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_cfg_valid,
    output logic          o_busy,
    output logic          o_cfg_ready,
    output logic          o_done,
    output tksl_pkg::t_cmd o_cmd
);
    import tksl_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CMP  = 3'b010,
        S_UPD  = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_done, n_done;
    logic   idle;

    assign idle = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_done = (r_state == S_UPD);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    assign o_busy      = !idle;
    assign o_cfg_ready = idle;
    assign o_done      = r_done;
    assign o_cmd       = '{capture: idle && i_start,
                           compare: (r_state == S_CMP),
                           update:  (r_state == S_UPD),
                           cfg_we:  idle && i_cfg_valid};

endmodule

@@ hdl/tksl_dp.sv @@
// Datapath of the score list: the entry cells, per-cell comparators, config registers
// and the result registers. Depends on tksl_pkg.
module tksl_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  tksl_pkg::t_cmd                    i_cmd,
    input  logic                              i_opcode,
    input  logic signed [tksl_pkg::SCORE_W-1:0] i_score,
    input  logic [tksl_pkg::TAG_W-1:0]        i_config_id,
    input  logic [tksl_pkg::TAG_W-1:0]        i_coeff_tag,
    input  logic [tksl_pkg::IDX_W-1:0]        i_read_index,
    input  logic [tksl_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tksl_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output logic                              o_accepted,
    output logic [tksl_pkg::IDX_W-1:0]        o_position,
    output logic [tksl_pkg::CNT_W-1:0]        o_entry_count,
    output logic                              o_overflow,
    output logic signed [tksl_pkg::SCORE_W-1:0] o_read_score,
    output logic [tksl_pkg::TAG_W-1:0]        o_read_config_id,
    output logic [tksl_pkg::TAG_W-1:0]        o_read_coeff_tag
);
    import tksl_pkg::*;

    // Entry cells. Cells at or past the count always hold zero.
    logic [SCORE_W-1:0] r_score [MAX_ENTRIES];
    logic [TAG_W-1:0]   r_cfg   [MAX_ENTRIES];
    logic [TAG_W-1:0]   r_coef  [MAX_ENTRIES];
    logic [SCORE_W-1:0] n_score [MAX_ENTRIES];
    logic [TAG_W-1:0]   n_cfg   [MAX_ENTRIES];
    logic [TAG_W-1:0]   n_coef  [MAX_ENTRIES];

    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_lsize, n_lsize;
    logic             r_call, n_call;

    // Captured item.
    logic               r_op;
    logic [SCORE_W-1:0] r_s;
    logic [TAG_W-1:0]   r_c;
    logic [TAG_W-1:0]   r_k;
    logic [IDX_W-1:0]   r_ridx;

    // Compare flags, one per cell, plus the head compares for collect-all mode.
    logic [MAX_ENTRIES-1:0] r_ge, r_eq;
    logic                   r_gt_head, r_ge_head;

    // Result registers.
    logic               r_acc, n_acc;
    logic [IDX_W-1:0]   r_pos, n_pos;
    logic [CNT_W-1:0]   r_rcnt, n_rcnt;
    logic               r_ovf, n_ovf;
    logic [SCORE_W-1:0] r_rs, n_rs;
    logic [TAG_W-1:0]   r_rc, n_rc;
    logic [TAG_W-1:0]   r_rk, n_rk;

    logic [MAX_ENTRIES-1:0] first, below_hit;
    logic                   any_ge, dup, ins;
    logic [IDX_W-1:0]       pos;
    logic                   nonempty, clr, take, place_ok;
    logic [CNT_W-1:0]       eff_cnt, nsz, keep;

    // Locate the first cell the offered score equals or beats.
    always_comb begin
        logic acc;
        acc = 1'b0;
        pos = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            below_hit[i] = acc;
            first[i]     = r_ge[i] && !acc;
            acc          = acc || r_ge[i];
        end
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (first[i]) begin
                pos = pos | IDX_W'(i);
            end
        end
        any_ge   = acc;
        dup      = |(first & r_eq);
        ins      = any_ge && !dup;
        nonempty = (r_count != '0);
        clr      = nonempty && r_gt_head;
        take     = !nonempty || r_ge_head;
        eff_cnt  = clr ? '0 : r_count;
        place_ok = take && (eff_cnt < CNT_W'(MAX_ENTRIES));
        nsz      = clamp_size(i_cfg_data[LSIZE_W-1:0]);
        keep     = (nsz < r_count) ? nsz : r_count;
    end

    always_comb begin
        n_score = r_score;
        n_cfg   = r_cfg;
        n_coef  = r_coef;
        n_count = r_count;
        n_lsize = r_lsize;
        n_call  = r_call;
        n_acc   = r_acc;
        n_pos   = r_pos;
        n_rcnt  = r_rcnt;
        n_ovf   = r_ovf;
        n_rs    = r_rs;
        n_rc    = r_rc;
        n_rk    = r_rk;

        if (i_cmd.cfg_we) begin
            case (i_cfg_index)
                CFG_LIST_SIZE: begin
                    // Resize: entries past the smaller of old and new size become zero.
                    for (int i = 0; i < MAX_ENTRIES; i++) begin
                        if (CNT_W'(i) >= keep) begin
                            n_score[i] = '0;
                            n_cfg[i]   = '0;
                            n_coef[i]  = '0;
                        end
                    end
                    n_lsize = nsz;
                    n_count = nsz;
                end
                CFG_COLLECT_ALL: begin
                    for (int i = 0; i < MAX_ENTRIES; i++) begin
                        n_score[i] = '0;
                        n_cfg[i]   = '0;
                        n_coef[i]  = '0;
                    end
                    n_call  = i_cfg_data[0];
                    n_count = i_cfg_data[0] ? '0 : r_lsize;
                end
                default: begin
                end
            endcase
        end

        if (i_cmd.update) begin
            n_acc = 1'b0;
            n_pos = '0;
            n_ovf = 1'b0;
            n_rs  = '0;
            n_rc  = '0;
            n_rk  = '0;
            if (r_op == OP_READ) begin
                if ({1'b0, r_ridx} < (IDX_W + 1)'(r_count)) begin
                    n_rs = r_score[r_ridx];
                    n_rc = r_cfg[r_ridx];
                    n_rk = r_coef[r_ridx];
                end
            end else if (r_call) begin
                if (clr) begin
                    for (int i = 0; i < MAX_ENTRIES; i++) begin
                        n_score[i] = '0;
                        n_cfg[i]   = '0;
                        n_coef[i]  = '0;
                    end
                end
                n_count = eff_cnt;
                if (take) begin
                    if (place_ok) begin
                        for (int i = 0; i < MAX_ENTRIES; i++) begin
                            if (CNT_W'(i) == eff_cnt) begin
                                n_score[i] = r_s;
                                n_cfg[i]   = r_c;
                                n_coef[i]  = r_k;
                            end
                        end
                        n_count = eff_cnt + CNT_W'(1);
                        n_acc   = 1'b1;
                        n_pos   = eff_cnt[IDX_W-1:0];
                    end else begin
                        n_ovf = 1'b1;
                    end
                end
            end else if (ins) begin
                // Cells below the hit shift down one place; the last valid one falls out.
                for (int i = 1; i < MAX_ENTRIES; i++) begin
                    if (below_hit[i] && (CNT_W'(i) < r_count)) begin
                        n_score[i] = r_score[i-1];
                        n_cfg[i]   = r_cfg[i-1];
                        n_coef[i]  = r_coef[i-1];
                    end
                end
                for (int i = 0; i < MAX_ENTRIES; i++) begin
                    if (first[i]) begin
                        n_score[i] = r_s;
                        n_cfg[i]   = r_c;
                        n_coef[i]  = r_k;
                    end
                end
                n_acc = 1'b1;
                n_pos = pos;
            end
            n_rcnt = n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                r_score[i] <= '0;
                r_cfg[i]   <= '0;
                r_coef[i]  <= '0;
            end
            r_count <= COUNT_RESET;
            r_lsize <= COUNT_RESET;
            r_call  <= 1'b0;
        end else begin
            r_score <= n_score;
            r_cfg   <= n_cfg;
            r_coef  <= n_coef;
            r_count <= n_count;
            r_lsize <= n_lsize;
            r_call  <= n_call;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= i_opcode;
            r_s    <= i_score;
            r_c    <= i_config_id;
            r_k    <= i_coeff_tag;
            r_ridx <= i_read_index;
        end
        if (i_cmd.compare) begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                r_ge[i] <= (CNT_W'(i) < r_count) && ($signed(r_s) >= $signed(r_score[i]));
                r_eq[i] <= (r_s == r_score[i]) && (r_c == r_cfg[i]);
            end
            r_gt_head <= $signed(r_s) >  $signed(r_score[0]);
            r_ge_head <= $signed(r_s) >= $signed(r_score[0]);
        end
        r_acc  <= n_acc;
        r_pos  <= n_pos;
        r_rcnt <= n_rcnt;
        r_ovf  <= n_ovf;
        r_rs   <= n_rs;
        r_rc   <= n_rc;
        r_rk   <= n_rk;
    end

    assign o_accepted       = r_acc;
    assign o_position       = r_pos;
    assign o_entry_count    = r_rcnt;
    assign o_overflow       = r_ovf;
    assign o_read_score     = $signed(r_rs);
    assign o_read_config_id = r_rc;
    assign o_read_coeff_tag = r_rk;

endmodule

@@ hdl/tksl_chk.sv @@
// Port-level checker of the score list, bound to the top level.
// Depends on tksl_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tksl_chk (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       start,
    input logic                       busy,
    input logic                       o_done,
    input logic                       o_accepted,
    input logic [tksl_pkg::CNT_W-1:0] o_entry_count,
    input logic                       o_overflow,
    input logic                       o_cfg_ready
);
    import tksl_pkg::*;

    // Every taken command yields its result beat after the compare and update steps.
    `TKSL_ASSERT_NOW(a_done_lat, i_clk, i_rst_n, start && !busy, ##3 o_done)
    // A result beat always follows a busy cycle.
    `TKSL_ASSERT_NOW(a_done_after_busy, i_clk, i_rst_n, o_done, $past(busy))
    // Overflow only on a full list, and never together with a store.
    `TKSL_ASSERT_NOW(a_ovf_full, i_clk, i_rst_n, o_done && o_overflow,
        !o_accepted && (o_entry_count == CNT_W'(MAX_ENTRIES)))
    // The count never exceeds the list depth.
    `TKSL_ASSERT_NOW(a_count_max, i_clk, i_rst_n, o_done,
        o_entry_count <= CNT_W'(MAX_ENTRIES))
    // No register write while a command is in flight.
    `TKSL_ASSERT_NOW(a_cfg_blocked, i_clk, i_rst_n, busy, !o_cfg_ready)

endmodule

bind top_k_score_list tksl_chk u_tksl_chk (.*);
